@@ hw/rtl/tlcl_pkg.sv @@
// shared types and constants for the two-level catalogue lookup core
package tlcl_pkg;

    // stream payload widths
    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 32;

    // field widths fixed by the item format
    localparam int INDEX_W = 10;
    localparam int KEY_W   = 32;
    localparam int REF_W   = 32;
    localparam int COUNT_W = 10;

    // s_tuser codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // table read address source
    typedef enum logic {
        RD_PROBE,
        RD_NEXT
    } rd_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic    tbl_wr;
        logic    load_query;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    step;
        logic    cap_first;
        logic    msg_init;
        logic    res_hit;
        logic    res_miss;
        logic    out_load;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic range_empty;
        logic key_eq;
        logic next_ok;
        logic run_ok;
    } status_t;

endpackage

@@ hw/rtl/two_level_catalogue_lookup_core.sv @@
// Two-level catalogue lookup: a key table of (key, ref) entries loaded by write
// transactions (s_tuser 0) and searched by query transactions
// (s_tuser 1). A query binary-searches the sorted set index in entries 0 to
// set_count-1, reads the hit entry's bounding neighbour, then binary-searches
// that set's message run, and returns one result: m_tuser is found, m_tdata the
// text offset (zero on a miss). Every probe uses the table's single read port;
// the set search needs at most log2(TABLE_DEPTH) probes and the message run at
// most one more. Besides its probes a query takes the accept step, the bounding
// read, the final empty-range test and the output load, and it holds the core
// from its acceptance to the next acceptance; an early hit or miss ends the
// search sooner. Write
// transactions give no result. The table memory is not cleared by reset; a
// query must only touch entries that have been written. One item is worked on
// at a time, and the next one is taken while a result waits in the output
// register.
module two_level_catalogue_lookup_core #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration: set_count
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tlcl_pkg::COUNT_W-1:0]    cfg_data,
    // input: entry_index, entry_key, entry_ref, set_number, message_number
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tlcl_pkg::S_TDATA_W-1:0]  s_tdata,
    // input: op
    input  logic [0:0]                      s_tuser,
    // result: text_offset
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tlcl_pkg::M_TDATA_W-1:0]  m_tdata,
    // result: found
    output logic [0:0]                      m_tuser
);

    tlcl_pkg::cmd_t    cmd;
    tlcl_pkg::status_t status;

    assign cfg_ready = 1'b1;

    tlcl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser[0]),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    tlcl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_set_count  (cfg_data),
        .entry_index    (s_tdata[9:0]),
        .entry_key      (s_tdata[41:10]),
        .entry_ref      (s_tdata[73:42]),
        .set_number     (s_tdata[105:74]),
        .message_number (s_tdata[137:106]),
        .cmd            (cmd),
        .status         (status),
        .found          (m_tuser[0]),
        .text_offset    (m_tdata)
    );

endmodule

@@ hw/rtl/tlcl_ctrl.sv @@
// controller state machine sequencing the set and message searches
module tlcl_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_op,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output tlcl_pkg::cmd_t    cmd,
    input  tlcl_pkg::status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET_PROBE,
        ST_SET_CMP,
        ST_CHECK,
        ST_MSG_PROBE,
        ST_MSG_CMP,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   accept;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = tlcl_pkg::RD_PROBE;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_op == tlcl_pkg::OP_WRITE) begin
                        cmd.tbl_wr = 1'b1;
                    end else begin
                        cmd.load_query = 1'b1;
                        state_next     = ST_SET_PROBE;
                    end
                end
            end
            ST_SET_PROBE: begin
                if (status.range_empty) begin
                    cmd.res_miss = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_SET_CMP;
                end
            end
            ST_SET_CMP: begin
                if (status.key_eq) begin
                    if (status.next_ok) begin
                        // ref of the hit entry is on hand; fetch the bounding entry
                        cmd.cap_first = 1'b1;
                        cmd.rd_en     = 1'b1;
                        cmd.rd_sel    = tlcl_pkg::RD_NEXT;
                        state_next    = ST_CHECK;
                    end else begin
                        cmd.res_miss = 1'b1;
                        state_next   = ST_DONE;
                    end
                end else begin
                    cmd.step   = 1'b1;
                    state_next = ST_SET_PROBE;
                end
            end
            ST_CHECK: begin
                if (status.run_ok) begin
                    cmd.msg_init = 1'b1;
                    state_next   = ST_MSG_PROBE;
                end else begin
                    cmd.res_miss = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_MSG_PROBE: begin
                if (status.range_empty) begin
                    cmd.res_miss = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_MSG_CMP;
                end
            end
            ST_MSG_CMP: begin
                if (status.key_eq) begin
                    cmd.res_hit = 1'b1;
                    state_next  = ST_DONE;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = ST_MSG_PROBE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

@@ hw/rtl/tlcl_dp.sv @@
// datapath: key table memory, search bounds, key compare and result registers
module tlcl_dp #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [tlcl_pkg::COUNT_W-1:0]      cfg_set_count,
    input  logic [tlcl_pkg::INDEX_W-1:0]      entry_index,
    input  logic [tlcl_pkg::KEY_W-1:0]        entry_key,
    input  logic [tlcl_pkg::REF_W-1:0]        entry_ref,
    input  logic [tlcl_pkg::KEY_W-1:0]        set_number,
    input  logic [tlcl_pkg::KEY_W-1:0]        message_number,
    input  tlcl_pkg::cmd_t                    cmd,
    output tlcl_pkg::status_t                 status,
    output logic                              found,
    output logic [tlcl_pkg::REF_W-1:0]        text_offset
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int EW = tlcl_pkg::KEY_W + tlcl_pkg::REF_W;
    localparam logic [AW:0] DEPTH_W  = (AW+1)'(TABLE_DEPTH);
    localparam logic [31:0] DEPTH_32 = 32'(TABLE_DEPTH);

    // key table, key in the low half and ref in the high half
    logic [EW-1:0] mem [TABLE_DEPTH];

    logic [tlcl_pkg::COUNT_W-1:0] set_count_reg;
    logic [tlcl_pkg::KEY_W-1:0]   set_want_reg;
    logic [tlcl_pkg::KEY_W-1:0]   msg_want_reg;
    logic                         msg_mode_reg;
    logic [AW:0]                  lo_reg, lo_next;
    logic [AW:0]                  hix_reg, hix_next;
    logic [AW-1:0]                probe_reg;
    logic [EW-1:0]                rd_data_reg;
    logic [tlcl_pkg::REF_W-1:0]   first_reg;
    logic                         res_found_reg;
    logic [tlcl_pkg::REF_W-1:0]   res_text_reg;
    logic                         out_found_reg;
    logic [tlcl_pkg::REF_W-1:0]   out_text_reg;

    logic [31:0]                  slot_32;
    logic [31:0]                  count_32;
    logic [AW:0]                  count_lim;
    logic [AW:0]                  span;
    logic [AW:0]                  probe_w;
    logic [AW:0]                  probe_inc;
    logic [AW-1:0]                rd_addr;
    logic [tlcl_pkg::KEY_W-1:0]   rd_key;
    logic [tlcl_pkg::REF_W-1:0]   rd_ref;
    logic [tlcl_pkg::KEY_W-1:0]   want;

    assign slot_32   = {{(32-tlcl_pkg::INDEX_W){1'b0}}, entry_index};
    assign count_32  = {{(32-tlcl_pkg::COUNT_W){1'b0}}, set_count_reg};
    assign count_lim = (count_32 > DEPTH_32) ? DEPTH_W : count_32[AW:0];

    // midpoint of the live range, valid while the range is not empty
    assign span      = hix_reg - lo_reg - (AW+1)'(1);
    assign probe_w   = lo_reg + (span >> 1);
    assign probe_inc = {1'b0, probe_reg} + (AW+1)'(1);

    assign rd_key = rd_data_reg[tlcl_pkg::KEY_W-1:0];
    assign rd_ref = rd_data_reg[EW-1:tlcl_pkg::KEY_W];
    assign want   = msg_mode_reg ? msg_want_reg : set_want_reg;

    assign rd_addr = (cmd.rd_sel == tlcl_pkg::RD_NEXT) ? probe_inc[AW-1:0] : probe_w[AW-1:0];

    // status back to the controller
    assign status.range_empty = (lo_reg >= hix_reg);
    assign status.key_eq      = (rd_key == want);
    assign status.next_ok     = (probe_inc < DEPTH_W);
    assign status.run_ok      = (rd_ref > first_reg) && (first_reg < DEPTH_32)
                                && (rd_ref <= DEPTH_32);

    // table write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.tbl_wr && (slot_32 < DEPTH_32)) begin
            mem[slot_32[AW-1:0]] <= {entry_ref, entry_key};
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // set count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_count_reg <= '0;
        end else if (cfg_we) begin
            set_count_reg <= cfg_set_count;
        end
    end

    // search bounds
    always_comb begin
        lo_next  = lo_reg;
        hix_next = hix_reg;
        if (cmd.load_query) begin
            lo_next  = '0;
            hix_next = count_lim;
        end else if (cmd.msg_init) begin
            lo_next  = first_reg[AW:0];
            hix_next = rd_ref[AW:0];
        end else if (cmd.step) begin
            if (rd_key < want) begin
                lo_next = probe_inc;
            end else begin
                hix_next = {1'b0, probe_reg};
            end
        end
    end

    // search and query registers
    always_ff @(posedge aclk) begin
        lo_reg  <= lo_next;
        hix_reg <= hix_next;
        if (cmd.load_query) begin
            set_want_reg <= set_number;
            msg_want_reg <= message_number;
            msg_mode_reg <= 1'b0;
        end else if (cmd.msg_init) begin
            msg_mode_reg <= 1'b1;
        end
        if (cmd.rd_en && (cmd.rd_sel == tlcl_pkg::RD_PROBE)) begin
            probe_reg <= probe_w[AW-1:0];
        end
        if (cmd.cap_first) begin
            first_reg <= rd_ref;
        end
    end

    // result and output registers
    always_ff @(posedge aclk) begin
        if (cmd.res_hit) begin
            res_found_reg <= 1'b1;
            res_text_reg  <= rd_ref;
        end else if (cmd.res_miss) begin
            res_found_reg <= 1'b0;
            res_text_reg  <= '0;
        end
        if (cmd.out_load) begin
            out_found_reg <= res_found_reg;
            out_text_reg  <= res_text_reg;
        end
    end

    assign found       = out_found_reg;
    assign text_offset = out_text_reg;

endmodule

@@ hw/rtl/tlcl_checker.sv @@
// port-level checker for the lookup core and its bind
module tlcl_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [0:0]                      s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tlcl_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [0:0]                      m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a miss reports a zero offset
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("miss with non-zero text offset");

    // a write transaction never raises a result
    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == tlcl_pkg::OP_WRITE && !m_tvalid
        |=> !m_tvalid)
        else $error("result after a write transaction");

    // a query keeps the input side busy in the next cycle
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == tlcl_pkg::OP_QUERY |=> !s_tready)
        else $error("input taken while a query runs");

    // no result straight out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind two_level_catalogue_lookup_core tlcl_checker u_tlcl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
